[sv/pmlut_pkg.sv]
// ----------------------------------------------------------------------------
// pmlut_pkg: shared types for the premultiplied RGBA tone mapper
// Holds the operation code that travels with each input word.
// ----------------------------------------------------------------------------
package pmlut_pkg;

  // Kind of input word: a table load or a pixel.
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

endpackage

[sv/pmlut_lane.sv]
// ----------------------------------------------------------------------------
// pmlut_lane: one colour channel lane
// Un-premultiplies one channel by a pipelined restoring divider, maps it
// through a private copy of the tone table and premultiplies it again.
// ----------------------------------------------------------------------------
module pmlut_lane
  import pmlut_pkg::*;
#(
  parameter int CB = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [CB-1:0] chan,
  input  logic [CB-1:0] alpha,
  input  logic          wr_vld,
  input  op_t           wr_op,
  input  logic [CB-1:0] wr_idx,
  input  logic [CB-1:0] wr_val,
  output logic [CB-1:0] res
);

  localparam int          DEPTH = 2 ** CB;
  localparam logic [CB-1:0] MAXV = {CB{1'b1}};
  localparam logic [2*CB-1:0] HALF = {{(CB+1){1'b0}}, {(CB-1){1'b1}}};

  // Divider stages: stage 0 holds the prepared numerator, stage k has k
  // quotient bits resolved.
  logic [CB-1:0] rem_r   [0:CB];
  logic [CB-1:0] low_r   [0:CB];
  logic [CB-1:0] quot_r  [0:CB];
  logic          sat_r   [0:CB];
  logic [CB-1:0] dalpha_r[0:CB];

  logic [2*CB-1:0] numer;

  assign numer = {chan, {CB{1'b0}}} - {{CB{1'b0}}, chan};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]    <= numer[2*CB-1:CB];
      low_r[0]    <= numer[CB-1:0];
      quot_r[0]   <= '0;
      sat_r[0]    <= (chan >= alpha);
      dalpha_r[0] <= alpha;
    end
  end

  genvar k;
  generate
    for (k = 1; k <= CB; k++) begin : g_div
      logic [CB:0] trial;
      logic [CB:0] diff;
      logic        ge;

      assign trial = {rem_r[k-1], low_r[k-1][CB-k]};
      assign ge    = (trial >= {1'b0, dalpha_r[k-1]});
      assign diff  = trial - {1'b0, dalpha_r[k-1]};

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k]    <= ge ? diff[CB-1:0] : trial[CB-1:0];
          low_r[k]    <= low_r[k-1];
          quot_r[k]   <= {quot_r[k-1][CB-2:0], ge};
          sat_r[k]    <= sat_r[k-1];
          dalpha_r[k] <= dalpha_r[k-1];
        end
      end
    end
  endgenerate

  // Tone table copy, written in stream order with the load words.
  logic [CB-1:0] tone_mem [0:DEPTH-1];
  logic [CB-1:0] unpre;
  logic [CB-1:0] tval_r;
  logic [CB-1:0] talpha_r;

  assign unpre = sat_r[CB] ? MAXV : quot_r[CB];

  always_ff @(posedge clk) begin
    if (en) begin
      if (wr_vld && (wr_op == OP_LOAD)) begin
        tone_mem[wr_idx] <= wr_val;
      end
      tval_r   <= tone_mem[unpre];
      talpha_r <= dalpha_r[CB];
    end
  end

  // Re-premultiply: product plus half, then division by MAXV as an
  // estimate followed by a single correction.
  logic [2*CB-1:0] prod_r;
  logic [2*CB-1:0] prod2_r;
  logic [2*CB-1:0] esum;
  logic [CB-1:0]   est_r;
  logic [2*CB-1:0] remd;
  logic [CB-1:0]   res_r;

  assign esum = prod_r + {{CB{1'b0}}, prod_r[2*CB-1:CB]};
  assign remd = prod2_r - {est_r, {CB{1'b0}}} + {{CB{1'b0}}, est_r};

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= (2*CB)'(tval_r * talpha_r) + HALF;
      est_r   <= esum[2*CB-1:CB];
      prod2_r <= prod_r;
      res_r   <= est_r + CB'(remd >= {{CB{1'b0}}, MAXV});
    end
  end

  assign res = res_r;

endmodule

[sv/pmlut_merge.sv]
// ----------------------------------------------------------------------------
// pmlut_merge: lane merge and output stage
// Joins the three lane results with alpha, applies the zero alpha bypass and
// holds the result in an output register backed by one skid register.
// ----------------------------------------------------------------------------
module pmlut_merge
  import pmlut_pkg::*;
#(
  parameter int CB = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           up_vld,
  input  op_t                            up_op,
  input  logic [CB-1:0]                  lane_r,
  input  logic [CB-1:0]                  lane_g,
  input  logic [CB-1:0]                  lane_b,
  input  logic [CB-1:0]                  orig_r,
  input  logic [CB-1:0]                  orig_g,
  input  logic [CB-1:0]                  orig_b,
  input  logic [CB-1:0]                  alpha,
  output logic                           up_ready,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [((4*CB+7)/8)*8-1:0]      out_tdata
);

  localparam int OUT_W = ((4*CB+7)/8)*8;
  localparam int PAD_W = OUT_W - 4*CB;

  logic [4*CB-1:0] word;
  logic            push;
  logic            pop;
  logic [4*CB-1:0] out_r, out_nxt;
  logic [4*CB-1:0] skid_r, skid_nxt;
  logic            out_vld_r, out_vld_nxt;
  logic            skid_vld_r, skid_vld_nxt;

  // A pixel with zero alpha leaves unchanged.
  assign word = (alpha == '0) ? {alpha, orig_b, orig_g, orig_r}
                              : {alpha, lane_b, lane_g, lane_r};

  assign up_ready = !skid_vld_r;
  assign push     = up_vld && (up_op == OP_PIXEL) && up_ready;
  assign pop      = out_vld_r && out_tready;

  always_comb begin
    out_nxt      = out_r;
    skid_nxt     = skid_r;
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (skid_vld_r) begin
      if (pop) begin
        out_nxt      = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (!out_vld_r || pop) begin
      out_nxt     = word;
      out_vld_nxt = push;
    end else if (push) begin
      skid_nxt     = word;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_r};

  a_skid_needs_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid register holds a word while the output register is empty");

  a_skid_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && !out_tready))
    else $error("skid register filled without an output stall");

endmodule

[sv/premultiplied_rgb_lut_mapper_core.sv]
// ----------------------------------------------------------------------------
// premultiplied_rgb_lut_mapper_core: premultiplied RGBA tone-table mapper
// Three channel lanes un-premultiply, map and re-premultiply one pixel word
// per cycle; load words fill the tone table in stream order.
// ----------------------------------------------------------------------------
// Each lane's divider resolves one quotient bit per stage.
// Throughput: one word per cycle; the pipeline holds only when the output
// register and its skid register are both full.
// Reset clears the valid bits of the pipeline and output stage only; the
// tone table is not cleared and must be loaded before pixels are sent.
// ----------------------------------------------------------------------------
module premultiplied_rgb_lut_mapper_core
  import pmlut_pkg::*;
#(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input words.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tdata, lowest bit up: table_index, table_value, red_in, green_in,
  // blue_in, alpha_in, zero padding to whole bytes.
  input  logic [((6*CHANNEL_BITS+7)/8)*8-1:0]  in_tdata,
  // tuser: operation (load or pixel).
  input  logic [0:0]                           in_tuser,
  // Result words.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // tdata, lowest bit up: red_out, green_out, blue_out, alpha_out, zero
  // padding to whole bytes.
  output logic [((4*CHANNEL_BITS+7)/8)*8-1:0]  out_tdata
);

  localparam int CB  = CHANNEL_BITS;
  // Stages from acceptance to the last lane register: the numerator
  // stage, CB divider stages, table read, multiply and two correction
  // stages.
  localparam int LAT = CB + 5;
  // The control word is looked at by the lanes when it reaches the table
  // stage, so that loads and reads keep their order.
  localparam int TBL = CB;

  typedef struct packed {
    op_t           op;
    logic [CB-1:0] idx;
    logic [CB-1:0] val;
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
    logic [CB-1:0] alpha;
  } ctl_t;

  logic          en;
  ctl_t          in_ctl;
  ctl_t          ctl_r [0:LAT-1];
  logic [LAT-1:0] vld_r;
  logic [CB-1:0] res_red;
  logic [CB-1:0] res_green;
  logic [CB-1:0] res_blue;

  // The whole lane pipeline advances together; it only holds once the
  // merge stage has a word waiting in its skid register.
  assign in_tready = en;

  assign in_ctl.op    = op_t'(in_tuser[0]);
  assign in_ctl.idx   = in_tdata[CB-1:0];
  assign in_ctl.val   = in_tdata[2*CB-1:CB];
  assign in_ctl.red   = in_tdata[3*CB-1:2*CB];
  assign in_ctl.green = in_tdata[4*CB-1:3*CB];
  assign in_ctl.blue  = in_tdata[5*CB-1:4*CB];
  assign in_ctl.alpha = in_tdata[6*CB-1:5*CB];

  // Valid bits follow each word down the pipeline; a stall freezes them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // Control and original pixel values travel alongside the lanes so that
  // the merge stage can pass a zero alpha pixel through untouched.
  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0] <= in_ctl;
      for (int i = 1; i < LAT; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  pmlut_lane #(.CB(CB)) u_lane_red (
    .clk    (clk),
    .en     (en),
    .chan   (in_ctl.red),
    .alpha  (in_ctl.alpha),
    .wr_vld (vld_r[TBL]),
    .wr_op  (ctl_r[TBL].op),
    .wr_idx (ctl_r[TBL].idx),
    .wr_val (ctl_r[TBL].val),
    .res    (res_red)
  );

  pmlut_lane #(.CB(CB)) u_lane_green (
    .clk    (clk),
    .en     (en),
    .chan   (in_ctl.green),
    .alpha  (in_ctl.alpha),
    .wr_vld (vld_r[TBL]),
    .wr_op  (ctl_r[TBL].op),
    .wr_idx (ctl_r[TBL].idx),
    .wr_val (ctl_r[TBL].val),
    .res    (res_green)
  );

  pmlut_lane #(.CB(CB)) u_lane_blue (
    .clk    (clk),
    .en     (en),
    .chan   (in_ctl.blue),
    .alpha  (in_ctl.alpha),
    .wr_vld (vld_r[TBL]),
    .wr_op  (ctl_r[TBL].op),
    .wr_idx (ctl_r[TBL].idx),
    .wr_val (ctl_r[TBL].val),
    .res    (res_blue)
  );

  // Load words end here; only pixel words are handed to the output.
  pmlut_merge #(.CB(CB)) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_vld     (vld_r[LAT-1]),
    .up_op      (ctl_r[LAT-1].op),
    .lane_r     (res_red),
    .lane_g     (res_green),
    .lane_b     (res_blue),
    .orig_r     (ctl_r[LAT-1].red),
    .orig_g     (ctl_r[LAT-1].green),
    .orig_b     (ctl_r[LAT-1].blue),
    .alpha      (ctl_r[LAT-1].alpha),
    .up_ready   (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  logic [CB-1:0] chk_red;
  logic [CB-1:0] chk_green;
  logic [CB-1:0] chk_blue;
  logic [CB-1:0] chk_alpha;

  assign chk_red   = out_tdata[CB-1:0];
  assign chk_green = out_tdata[2*CB-1:CB];
  assign chk_blue  = out_tdata[3*CB-1:2*CB];
  assign chk_alpha = out_tdata[4*CB-1:3*CB];

  // Re-premultiplying a mapped level can never give more than alpha.
  a_chan_le_alpha : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (chk_alpha != '0)) |->
      ((chk_red <= chk_alpha) && (chk_green <= chk_alpha) && (chk_blue <= chk_alpha)))
    else $error("mapped colour channel exceeds alpha");

  // The input side is only held off while a result is waiting.
  a_hold_needs_out : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input held off with no result pending");

endmodule
